>>> rtl/point_in_polygon_test_unit_assert.svh
// assertion macros used by the point in polygon test rtl
`ifndef POINT_IN_POLYGON_TEST_UNIT_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define PIPT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PIPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PIPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pipt_pkg.sv
// package with sizes, types and codes of the point in polygon test unit
`timescale 1ns / 1ps

package pipt_pkg;

	// polygon capacity and coordinate width
	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;

	// derived widths
	localparam int IDX_BITS  = $clog2(MAX_VERTICES);
	localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int DOT_BITS  = PROD_BITS + 1;
	localparam int VERT_BITS = 2 * COORD_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [DOT_BITS-1:0]   dot_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;
	typedef logic [IDX_BITS-1:0]          idx_t;
	typedef logic [1:0]                   loc_t;

	// request operations
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// location codes
	localparam loc_t LOC_OUTSIDE  = 2'd0;
	localparam loc_t LOC_BOUNDARY = 2'd1;
	localparam loc_t LOC_INSIDE   = 2'd2;

endpackage

>>> rtl/pipt_if.sv
// request and response channel interfaces of the point in polygon test unit
`timescale 1ns / 1ps

interface pipt_req_if;
	import pipt_pkg::*;

	logic   valid;
	logic   ready;
	logic   operation;
	coord_t coord_x;
	coord_t coord_y;
	logic   restart;

	modport source (output valid, output operation, output coord_x, output coord_y,
		output restart, input ready);
	modport sink (input valid, input operation, input coord_x, input coord_y,
		input restart, output ready);
endinterface

interface pipt_rsp_if;
	import pipt_pkg::*;

	logic valid;
	logic ready;
	loc_t location;
	logic overflowed;

	modport source (output valid, output location, output overflowed, input ready);
	modport sink (input valid, input location, input overflowed, output ready);
endinterface

>>> rtl/pipt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pipt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/point_in_polygon_test_unit.sv
// point in polygon test unit: vertex store, edge sequencer and shared multiplier
//
//   channel  dir  payload                               request completes
//   req      in   operation, coord_x, coord_y, restart  valid & ready
//   rsp      out  location, overflowed                  valid & ready
//
// an add request gives no response and leaves req.ready high for the next request.
// a query walks a first-vertex step, then per edge an address, a ram read (none on the
// closing edge), four products on the one multiplier and a compare, and then raises
// rsp.valid. a point found on an edge ends the walk early. an empty polygon answers in
// the cycle after acceptance; req.ready is low until the response is taken.
// reset clears the vertex count, overflow flag and sequencer; the vertex ram is not cleared.
`timescale 1ns / 1ps

`include "point_in_polygon_test_unit_assert.svh"

module point_in_polygon_test_unit (
	input  logic      clk,
	input  logic      arst_n,
	pipt_req_if.sink  req,
	pipt_rsp_if.source rsp
);
	import pipt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_FETCH,
		ST_LOAD,
		ST_MUL,
		ST_EVAL,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		PH_CROSS_L,
		PH_CROSS_R,
		PH_DOT_X,
		PH_DOT_Y
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	cnt_t   count_q;
	cnt_t   idx_q;
	logic   ovf_q;
	logic   par_q;
	logic   rsp_valid_q;
	loc_t   rsp_loc_q;
	logic   rsp_ovf_q;

	coord_t a_x_q, a_y_q, b_x_q, b_y_q, p_x_q, p_y_q, first_x_q, first_y_q;
	prod_t  prod_l_q, prod_r_q, prod_dx_q, prod_dy_q;

	logic                 req_fire;
	logic                 is_add;
	logic                 is_query;
	logic                 full;
	logic                 last_edge;
	logic                 wr_en;
	idx_t                 wr_addr;
	logic                 rd_en;
	idx_t                 rd_addr;
	logic [VERT_BITS-1:0] rd_data;
	coord_t               rd_x, rd_y;

	coord_t m1, s1, m2, s2;
	diff_t  op1, op2;
	prod_t  mul_res;

	logic cross_zero, cross_pos, on_edge, upward, spans, turn_pos, crosses;
	dot_t dot;
	coord_t low_y, high_y;

	function automatic diff_t sub_ext(coord_t a, coord_t b);
		diff_t ae, be;
		ae = {a[COORD_BITS-1], a};
		be = {b[COORD_BITS-1], b};
		return ae - be;
	endfunction

	// handshake and request decode
	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign is_add     = req_fire && (req.operation == OP_ADD);
	assign is_query   = req_fire && (req.operation == OP_QUERY);
	assign full       = (count_q == CNT_BITS'(MAX_VERTICES));
	assign last_edge  = (idx_q == count_q);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.location   = rsp_loc_q;
	assign rsp.overflowed = rsp_ovf_q;

	// vertex store write and read addressing
	assign wr_en   = is_add && (req.restart || !full);
	assign wr_addr = req.restart ? '0 : count_q[IDX_BITS-1:0];
	assign rd_en   = (is_query && (count_q != '0)) || ((state_q == ST_FETCH) && !last_edge);
	assign rd_addr = (state_q == ST_IDLE) ? '0 : idx_q[IDX_BITS-1:0];
	assign rd_x    = rd_data[VERT_BITS-1:COORD_BITS];
	assign rd_y    = rd_data[COORD_BITS-1:0];

	pipt_ram #(
		.WIDTH (VERT_BITS),
		.DEPTH (MAX_VERTICES)
	) u_vert_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({req.coord_x, req.coord_y}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// operand selection for the shared multiplier
	always_comb begin
		case (phase_q)
			PH_CROSS_L: begin
				m1 = b_x_q; s1 = a_x_q; m2 = p_y_q; s2 = b_y_q;
			end
			PH_CROSS_R: begin
				m1 = b_y_q; s1 = a_y_q; m2 = p_x_q; s2 = b_x_q;
			end
			PH_DOT_X: begin
				m1 = p_x_q; s1 = a_x_q; m2 = b_x_q; s2 = p_x_q;
			end
			PH_DOT_Y: begin
				m1 = p_y_q; s1 = a_y_q; m2 = b_y_q; s2 = p_y_q;
			end
			default: begin
				m1 = b_x_q; s1 = a_x_q; m2 = p_y_q; s2 = b_y_q;
			end
		endcase
	end

	assign op1     = sub_ext(m1, s1);
	assign op2     = sub_ext(m2, s2);
	assign mul_res = PROD_BITS'(op1) * PROD_BITS'(op2);

	// edge evaluation from the four products
	assign cross_zero = (prod_l_q == prod_r_q);
	assign cross_pos  = (prod_l_q > prod_r_q);
	assign dot        = DOT_BITS'(prod_dx_q) + DOT_BITS'(prod_dy_q);
	assign on_edge    = cross_zero && !dot[DOT_BITS-1];
	assign upward     = (b_y_q > a_y_q);
	assign low_y      = upward ? a_y_q : b_y_q;
	assign high_y     = upward ? b_y_q : a_y_q;
	assign spans      = (low_y <= p_y_q) && (p_y_q < high_y);
	// turning the edge upward flips the cross product sign
	assign turn_pos   = upward ? cross_pos : (!cross_pos && !cross_zero);
	assign crosses    = (a_y_q != b_y_q) && spans && turn_pos;

	// sequencer, polygon state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_CROSS_L;
			count_q     <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			par_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_loc_q   <= LOC_OUTSIDE;
			rsp_ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (is_add) begin
						if (req.restart) begin
							count_q <= CNT_BITS'(1);
							ovf_q   <= 1'b0;
						end else if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_BITS'(1);
						end
					end else if (is_query) begin
						par_q     <= 1'b0;
						rsp_ovf_q <= ovf_q;
						if (count_q == '0) begin
							rsp_loc_q   <= LOC_OUTSIDE;
							rsp_valid_q <= 1'b1;
							state_q     <= ST_RESP;
						end else begin
							state_q <= ST_FIRST;
						end
					end
				end
				ST_FIRST: begin
					idx_q   <= CNT_BITS'(1);
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					phase_q <= PH_CROSS_L;
					state_q <= last_edge ? ST_MUL : ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					case (phase_q)
						PH_CROSS_L: phase_q <= PH_CROSS_R;
						PH_CROSS_R: phase_q <= PH_DOT_X;
						PH_DOT_X:   phase_q <= PH_DOT_Y;
						default:    state_q <= ST_EVAL;
					endcase
				end
				ST_EVAL: begin
					if (on_edge) begin
						rsp_loc_q   <= LOC_BOUNDARY;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_RESP;
					end else if (last_edge) begin
						rsp_loc_q   <= (par_q ^ crosses) ? LOC_INSIDE : LOC_OUTSIDE;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_RESP;
					end else begin
						par_q   <= par_q ^ crosses;
						idx_q   <= idx_q + CNT_BITS'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_RESP: begin
					if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// edge endpoints, query point and products
	always_ff @(posedge clk) begin
		if (is_query) begin
			p_x_q <= req.coord_x;
			p_y_q <= req.coord_y;
		end
		if (state_q == ST_FIRST) begin
			a_x_q     <= rd_x;
			a_y_q     <= rd_y;
			first_x_q <= rd_x;
			first_y_q <= rd_y;
		end
		if ((state_q == ST_FETCH) && last_edge) begin
			b_x_q <= first_x_q;
			b_y_q <= first_y_q;
		end
		if (state_q == ST_LOAD) begin
			b_x_q <= rd_x;
			b_y_q <= rd_y;
		end
		if ((state_q == ST_EVAL) && !last_edge) begin
			a_x_q <= b_x_q;
			a_y_q <= b_y_q;
		end
		if (state_q == ST_MUL) begin
			case (phase_q)
				PH_CROSS_L: prod_l_q  <= mul_res;
				PH_CROSS_R: prod_r_q  <= mul_res;
				PH_DOT_X:   prod_dx_q <= mul_res;
				default:    prod_dy_q <= mul_res;
			endcase
		end
	end

	// checks
	`PIPT_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_BITS'(MAX_VERTICES),
		"vertex count above capacity")
	`PIPT_ASSERT_SAME(a_no_overlap, clk, arst_n, req.ready, !rsp.valid,
		"request taken while a response is pending")
	`PIPT_ASSERT_NEXT(a_empty_query, clk, arst_n, is_query && (count_q == '0),
		rsp.valid && (rsp.location == LOC_OUTSIDE), "empty polygon query not answered outside")
	`PIPT_ASSERT_NEXT(a_boundary_hit, clk, arst_n, (state_q == ST_EVAL) && on_edge,
		rsp.valid && (rsp.location == LOC_BOUNDARY), "edge hit not answered as boundary")
	`PIPT_ASSERT_NEXT(a_restart, clk, arst_n, is_add && req.restart,
		(count_q == CNT_BITS'(1)) && !ovf_q, "restart did not leave a single vertex")

endmodule

>>> tb/point_in_polygon_test_unit_tb.sv
// testbench of the point in polygon test unit: directed and random requests, scoreboard check
`timescale 1ns / 1ps

module point_in_polygon_test_unit_tb;
	import pipt_pkg::*;

	// run sizes
	localparam int ITEM_TARGET     = 700;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int SETTLE_CYCLES   = 7 * MAX_VERTICES + 50;
	localparam coord_t COORD_MIN   = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coord_t COORD_MAX   = {1'b0, {(COORD_BITS-1){1'b1}}};

	// how random coordinates are drawn
	typedef enum int {COORD_NEAR, COORD_ANY, COORD_EDGE} coord_mode_t;

	typedef struct packed {
		loc_t location;
		logic overflowed;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;

	pipt_req_if req_ch ();
	pipt_rsp_if rsp_ch ();

	point_in_polygon_test_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// polygon as the block should hold it
	coord_t  polygon_x [MAX_VERTICES];
	coord_t  polygon_y [MAX_VERTICES];
	int      polygon_size = 0;
	logic    dropped_flag = 1'b0;
	answer_t expected_answers [$];

	int   error_count = 0;
	int   items_sent = 0;
	int   add_count = 0;
	int   query_count = 0;
	int   seen_outside = 0;
	int   seen_boundary = 0;
	int   seen_inside = 0;
	int   seen_overflow = 0;
	bit   req_pauses_on = 1'b1;
	bit   rsp_pauses_on = 1'b1;
	logic hold_on;
	event hold_go;

	// clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// pause lengths: mostly short, a few long
	function automatic int pick_pause_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic coord_t pick_coord(coord_mode_t mode);
		case (mode)
			COORD_NEAR: return coord_t'(int'($urandom_range(0, 32)) - 16);
			COORD_EDGE: begin
				case ($urandom_range(0, 4))
					0:       return COORD_MIN;
					1:       return coord_t'(COORD_MIN + 1);
					2:       return '0;
					3:       return coord_t'(COORD_MAX - 1);
					default: return COORD_MAX;
				endcase
			end
			default: return coord_t'($urandom());
		endcase
	endfunction

	// sign of (b - a) x (c - b), exact in 64 bits
	function automatic int turn_dir(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy);
		longint lhs;
		longint rhs;
		lhs = (bx - ax) * (cy - by);
		rhs = (by - ay) * (cx - bx);
		if (lhs > rhs)
			return 1;
		if (lhs < rhs)
			return -1;
		return 0;
	endfunction

	// crossing number over the stored polygon, boundary found first
	function automatic loc_t predict_location(coord_t qx, coord_t qy);
		longint px, py, ax, ay, bx, by, t, dot;
		int crossings;
		int nxt;
		px = qx;
		py = qy;
		crossings = 0;
		for (int i = 0; i < polygon_size; i++) begin
			nxt = (i + 1 == polygon_size) ? 0 : i + 1;
			ax = polygon_x[i];
			ay = polygon_y[i];
			bx = polygon_x[nxt];
			by = polygon_y[nxt];
			if (turn_dir(ax, ay, bx, by, px, py) == 0) begin
				dot = (px - ax) * (bx - px) + (py - ay) * (by - py);
				if (dot >= 0)
					return LOC_BOUNDARY;
			end
			if (ay == by)
				continue;
			// orient the edge upward
			if (by < ay) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			// half-open span in y
			if (by <= py || ay > py)
				continue;
			if (turn_dir(ax, ay, bx, by, px, py) > 0)
				crossings++;
		end
		return crossings[0] ? LOC_INSIDE : LOC_OUTSIDE;
	endfunction

	// update the polygon or queue the expected answer for an accepted request
	function automatic void record_request(logic op, coord_t x, coord_t y, logic rst);
		answer_t ans;
		if (op == OP_ADD) begin
			add_count++;
			if (rst) begin
				polygon_size = 0;
				dropped_flag = 1'b0;
			end
			if (polygon_size < MAX_VERTICES) begin
				polygon_x[polygon_size] = x;
				polygon_y[polygon_size] = y;
				polygon_size++;
			end else begin
				dropped_flag = 1'b1;
			end
		end else begin
			query_count++;
			ans.location   = predict_location(x, y);
			ans.overflowed = dropped_flag;
			expected_answers.insert(expected_answers.size(), ans);
		end
	endfunction

	// offer one request and wait for it to be taken
	task automatic send_request(logic op, coord_t x, coord_t y, logic rst);
		int pause;
		pause = (req_pauses_on && $urandom_range(0, 3) == 0) ? pick_pause_len() : 0;
		if (pause > 0) begin
			req_ch.valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.coord_x   <= x;
		req_ch.coord_y   <= y;
		req_ch.restart   <= rst;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		record_request(op, x, y, rst);
		items_sent++;
	endtask

	task automatic add_vertex(coord_t x, coord_t y, logic rst);
		send_request(OP_ADD, x, y, rst);
	endtask

	task automatic query_point(coord_t x, coord_t y, logic rst = 1'b0);
		send_request(OP_QUERY, x, y, rst);
	endtask

	// compare one taken response with the oldest expected answer
	task automatic check_answer();
		answer_t want;
		case (rsp_ch.location)
			LOC_OUTSIDE:  seen_outside++;
			LOC_BOUNDARY: seen_boundary++;
			LOC_INSIDE:   seen_inside++;
			default: ;
		endcase
		if (rsp_ch.overflowed === 1'b1)
			seen_overflow++;
		if (expected_answers.size() == 0) begin
			$error("response with no query outstanding: location %0d overflowed %0b",
				rsp_ch.location, rsp_ch.overflowed);
			error_count++;
		end else begin
			want = expected_answers.pop_front();
			if (rsp_ch.location !== want.location) begin
				$error("location mismatch: expected %0d, actual %0d",
					want.location, rsp_ch.location);
				error_count++;
			end
			if (rsp_ch.overflowed !== want.overflowed) begin
				$error("overflowed mismatch: expected %0b, actual %0b",
					want.overflowed, rsp_ch.overflowed);
				error_count++;
			end
		end
	endtask

	// response side: check, then choose ready for the next cycle
	initial begin : response_sink
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				check_answer();
			if (hold_on) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rsp_pauses_on && $urandom_range(0, 4) == 0)
					stall_left = pick_pause_len();
			end
		end
	end

	// long hold-off of the response side, counted here
	initial begin : response_hold
		hold_on = 1'b0;
		forever begin
			@(hold_go);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// extremes, degenerate polygons, half-open ray ties
	task automatic test_corner_cases();
		// empty polygon, restart ignored on a query
		query_point(16'sd0, 16'sd0, 1'b1);
		// single vertex
		add_vertex(COORD_MIN, COORD_MAX, 1'b1);
		query_point(COORD_MIN, COORD_MAX);
		query_point(COORD_MAX, COORD_MIN);
		// two vertices along the full diagonal
		add_vertex(COORD_MIN, COORD_MIN, 1'b1);
		add_vertex(COORD_MAX, COORD_MAX, 1'b0);
		query_point(-16'sd1, -16'sd1);
		query_point(16'sd0, 16'sd1);
		// full-range square
		add_vertex(COORD_MIN, COORD_MIN, 1'b1);
		add_vertex(COORD_MAX, COORD_MIN, 1'b0);
		add_vertex(COORD_MAX, COORD_MAX, 1'b0);
		add_vertex(COORD_MIN, COORD_MAX, 1'b0);
		query_point(16'sd0, 16'sd0);
		query_point(COORD_MAX, 16'sd0);
		// triangle with a horizontal base, ray through vertex heights
		add_vertex(16'sd0, 16'sd0, 1'b1);
		add_vertex(16'sd10, 16'sd0, 1'b0);
		add_vertex(16'sd5, 16'sd10, 1'b0);
		query_point(16'sd5, 16'sd0);
		query_point(-16'sd5, 16'sd0);
		query_point(16'sd5, 16'sd5);
		query_point(16'sd5, 16'sd10);
		query_point(-16'sd5, 16'sd10);
	endtask

	// fill the store, drop past capacity, then clear with a restart
	task automatic test_capacity();
		add_vertex(pick_coord(COORD_ANY), pick_coord(COORD_ANY), 1'b1);
		for (int k = 1; k < MAX_VERTICES; k++)
			add_vertex(pick_coord(COORD_ANY), pick_coord(COORD_ANY), 1'b0);
		query_point(pick_coord(COORD_ANY), pick_coord(COORD_ANY));
		add_vertex(pick_coord(COORD_ANY), pick_coord(COORD_ANY), 1'b0);
		add_vertex(pick_coord(COORD_ANY), pick_coord(COORD_ANY), 1'b0);
		query_point(pick_coord(COORD_ANY), pick_coord(COORD_ANY));
		query_point(polygon_x[0], polygon_y[0]);
		add_vertex(16'sd3, 16'sd3, 1'b1);
		query_point(16'sd3, 16'sd3);
	endtask

	// response side held off while queries keep coming
	task automatic test_backpressure();
		req_pauses_on = 1'b0;
		add_vertex(-16'sd20, -16'sd20, 1'b1);
		add_vertex(16'sd20, -16'sd20, 1'b0);
		add_vertex(16'sd0, 16'sd20, 1'b0);
		-> hold_go;
		for (int k = 0; k < 6; k++)
			query_point(pick_coord(COORD_NEAR), pick_coord(COORD_NEAR));
		req_pauses_on = 1'b1;
	endtask

	// random polygons, mostly small, queried near vertices, edges and at random
	task automatic test_random_polygons();
		int n, nq, r, a, b;
		coord_mode_t mode;
		coord_t px, py;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				n = $urandom_range(1, 2);
			else if (r < 85)
				n = $urandom_range(3, 10);
			else if (r < 97)
				n = $urandom_range(11, 40);
			else
				n = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 6);
			r = $urandom_range(0, 99);
			mode = (r < 45) ? COORD_NEAR : (r < 80) ? COORD_ANY : COORD_EDGE;
			// some stretches run with no pauses at all
			req_pauses_on = ($urandom_range(0, 4) != 0);
			rsp_pauses_on = ($urandom_range(0, 4) != 0);
			// the odd polygon appends to the last one or restarts half way
			for (int k = 0; k < n; k++)
				add_vertex(pick_coord(mode), pick_coord(mode),
					(k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0));
			nq = $urandom_range(2, 8);
			for (int k = 0; k < nq; k++) begin
				r = $urandom_range(0, 99);
				a = $urandom_range(0, polygon_size - 1);
				b = (a + 1 == polygon_size) ? 0 : a + 1;
				if (r < 25) begin
					px = polygon_x[a];
					py = polygon_y[a];
				end else if (r < 50) begin
					px = coord_t'((int'(polygon_x[a]) + int'(polygon_x[b])) >>> 1);
					py = coord_t'((int'(polygon_y[a]) + int'(polygon_y[b])) >>> 1);
				end else if (r < 60) begin
					px = coord_t'(int'(polygon_x[a]) + int'($urandom_range(0, 2)) - 1);
					py = coord_t'(int'(polygon_y[a]) + int'($urandom_range(0, 2)) - 1);
				end else begin
					px = pick_coord(mode);
					py = pick_coord(mode);
				end
				query_point(px, py, $urandom_range(0, 19) == 0);
			end
		end
		req_pauses_on = 1'b1;
		rsp_pauses_on = 1'b1;
	endtask

	// main sequence
	initial begin : main_sequence
		int waited;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_ADD;
		req_ch.coord_x   = '0;
		req_ch.coord_y   = '0;
		req_ch.restart   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_capacity();
		test_backpressure();
		test_random_polygons();
		req_ch.valid <= 1'b0;

		// drain outstanding answers, then watch for strays
		waited = 0;
		while (expected_answers.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_answers.size() != 0) begin
			$error("%0d answers still outstanding after drain", expected_answers.size());
			error_count++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d adds and %0d queries (%0d outside, %0d boundary, %0d inside)",
			add_count, query_count, seen_outside, seen_boundary, seen_inside);
		$display("answers with overflow flag set: %0d, long response hold-off included",
			seen_overflow);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// overall time limit
	initial begin : watchdog
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
